>>> sv/overlapping_sum_pool_3x3_assert.svh
// Assertion macros shared by the pooling block.
// Each macro expects a clock named clk and a reset named rst in scope.
`ifndef OVERLAPPING_SUM_POOL_3X3_ASSERT_SVH
`define OVERLAPPING_SUM_POOL_3X3_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define OSP_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, checked outside reset.
`define OSP_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

>>> sv/osp_pkg.sv
`timescale 1ns / 1ps
package osp_pkg;

  localparam int RESP_W      = 24;
  localparam int SUM_W       = 31;
  localparam int IDX_W       = 4;
  localparam int MAP_NUM_W   = 10;
  localparam int CFG_W       = 11;
  localparam int GRID_MAX    = 4;

  localparam int MAP_SIDE_DEF    = 25;
  localparam int WINDOW_STEP_DEF = 8;
  localparam int GRID_SIDE_DEF   = 3;
  localparam int QUEUE_DEPTH     = 2;

  localparam logic [CFG_W-1:0] MAP_COUNT_RST = CFG_W'(256);

  localparam logic signed [SUM_W-1:0] SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
  localparam logic signed [SUM_W-1:0] SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};

  // One classified input value on its way from the front to the back.
  typedef struct packed {
    logic signed [RESP_W-1:0]    response;
    logic        [GRID_MAX-1:0]  row_hit;
    logic        [GRID_MAX-1:0]  col_hit;
    logic                        map_end;
    logic        [MAP_NUM_W-1:0] map_number;
  } osp_item_t;

  // Adds a value into a sum and clamps the result to the signed sum range.
  function automatic logic signed [SUM_W-1:0] sat_add(
    input logic signed [SUM_W-1:0]  a,
    input logic signed [RESP_W-1:0] b
  );
    logic signed [SUM_W:0] s;
    s = (SUM_W+1)'(a) + (SUM_W+1)'(b);
    if (s[SUM_W] != s[SUM_W-1]) begin
      return s[SUM_W] ? SUM_MIN : SUM_MAX;
    end
    return s[SUM_W-1:0];
  endfunction

endpackage

>>> sv/osp_ifs.sv
`timescale 1ns / 1ps
interface osp_resp_if;
  import osp_pkg::*;
  logic                     valid;
  logic                     ready;
  logic signed [RESP_W-1:0] response;
  modport source (output valid, output response, input ready);
  modport sink (input valid, input response, output ready);
endinterface

interface osp_pool_if;
  import osp_pkg::*;
  logic                        valid;
  logic                        ready;
  logic signed [SUM_W-1:0]     region_sum;
  logic        [IDX_W-1:0]     region_index;
  logic        [MAP_NUM_W-1:0] map_number;
  logic                        last_region;
  modport source (output valid, output region_sum, output region_index,
                  output map_number, output last_region, input ready);
  modport sink (input valid, input region_sum, input region_index,
                input map_number, input last_region, output ready);
endinterface

>>> sv/overlapping_sum_pool_3x3.sv
`timescale 1ns / 1ps
// Overlapping 3x3 sum pooling of a 25x25 response map.
// Input channel resp carries one signed Q11.12 value per transfer, in raster order,
// 625 transfers per map. Output channel pool carries nine window sums per map, in
// region order, each with its region index, map number and a last flag on the ninth.
// The map number wraps at the count written through cfg_wen / cfg_wdata (reset 256);
// write it only while the block is idle.
// Throughput: one input transfer per cycle while resp.ready is high. The front
// classifies each value by window in the cycle it is taken; a two-entry queue feeds
// the back, which adds it into up to four of the nine saturating accumulators at once.
// Output: pool.valid rises once the last value of a map has passed through the queue
// and its sums are loaded into a shift bank; the nine sums then leave it at one per
// cycle while pool.ready is high.
// While the receiver stalls, inputs keep flowing into the accumulators of the next
// map; only a following map end waits for the bank, after which the queue fills and
// resp.ready drops.
// Synchronous reset clears the sums, the raster position, the map number and the
// queue, and sets the map count to 256.
module overlapping_sum_pool_3x3 #(
  parameter int MAP_SIDE    = osp_pkg::MAP_SIDE_DEF,
  parameter int WINDOW_STEP = osp_pkg::WINDOW_STEP_DEF,
  parameter int GRID_SIDE   = osp_pkg::GRID_SIDE_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_wen,
  input  logic [osp_pkg::CFG_W-1:0] cfg_wdata,
  osp_resp_if.sink                  resp,
  osp_pool_if.source                pool
);
  import osp_pkg::*;

  // Front to queue.
  logic      q_push;
  logic      q_ready;
  osp_item_t q_in_item;

  // Queue to back.
  logic      q_valid;
  logic      q_pop;
  osp_item_t q_out_item;

  // Handshake terms used by the checks below.
  logic             pool_xfer;
  logic             run_step;
  logic             run_end;
  logic             map_end_pop;
  logic [IDX_W-1:0] idx_plus1;

  osp_front #(
    .MAP_SIDE    (MAP_SIDE),
    .WINDOW_STEP (WINDOW_STEP),
    .GRID_SIDE   (GRID_SIDE)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_wen   (cfg_wen),
    .cfg_wdata (cfg_wdata),
    .resp      (resp),
    .q_push    (q_push),
    .q_item    (q_in_item),
    .q_ready   (q_ready)
  );

  osp_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_item (q_in_item),
    .ready     (q_ready),
    .valid     (q_valid),
    .pop_item  (q_out_item),
    .pop       (q_pop)
  );

  osp_back #(
    .GRID_SIDE (GRID_SIDE)
  ) u_back (
    .clk     (clk),
    .rst     (rst),
    .q_valid (q_valid),
    .q_item  (q_out_item),
    .q_pop   (q_pop),
    .pool    (pool)
  );

  assign pool_xfer   = pool.valid && pool.ready;
  assign run_step    = pool_xfer && !pool.last_region;
  assign run_end     = pool_xfer && pool.last_region;
  assign map_end_pop = q_pop && q_out_item.map_end;
  assign idx_plus1   = pool.region_index + IDX_W'(1);

  `include "overlapping_sum_pool_3x3_assert.svh"

  // Within a run the region index steps by one per transfer.
  `OSP_ASSERT_NEXT(a_index_steps, run_step, pool.valid && pool.region_index == $past(idx_plus1))
  // All sums of one run carry the same map number.
  `OSP_ASSERT_NEXT(a_map_steady, run_step, pool.map_number == $past(pool.map_number))
  // A new run always starts at region zero.
  `OSP_ASSERT_NEXT(a_run_restart, run_end, !pool.valid || (pool.region_index == '0))
  // A map end leaves the queue only when the shift bank is free or freeing.
  `OSP_ASSERT_IMPL(a_bank_free, map_end_pop && pool.valid, pool.ready && pool.last_region)

endmodule

>>> sv/osp_front.sv
`timescale 1ns / 1ps
module osp_front #(
  parameter int MAP_SIDE    = osp_pkg::MAP_SIDE_DEF,
  parameter int WINDOW_STEP = osp_pkg::WINDOW_STEP_DEF,
  parameter int GRID_SIDE   = osp_pkg::GRID_SIDE_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_wen,
  input  logic [osp_pkg::CFG_W-1:0] cfg_wdata,
  osp_resp_if.sink                  resp,
  output logic                      q_push,
  output osp_pkg::osp_item_t        q_item,
  input  logic                      q_ready
);
  import osp_pkg::*;

  localparam int POS_W = $clog2(MAP_SIDE);

  logic [POS_W-1:0]     row;
  logic [POS_W-1:0]     col;
  logic [MAP_NUM_W-1:0] map_counter;
  logic [CFG_W-1:0]     map_count;
  logic                 col_end;
  logic                 row_end;
  logic [CFG_W-1:0]     map_next_wide;

  assign resp.ready = q_ready;
  assign q_push     = resp.valid && q_ready;

  assign col_end       = (col == POS_W'(MAP_SIDE - 1));
  assign row_end       = (row == POS_W'(MAP_SIDE - 1));
  assign map_next_wide = CFG_W'(map_counter) + CFG_W'(1);

  // Window g spans positions g*step through g*step+step inclusive.
  always_comb begin
    q_item.response   = resp.response;
    q_item.map_end    = col_end && row_end;
    q_item.map_number = map_counter;
    for (int g = 0; g < GRID_MAX; g++) begin
      q_item.row_hit[g] = (g < GRID_SIDE) && (int'(row) >= g * WINDOW_STEP) &&
                          (int'(row) <= g * WINDOW_STEP + WINDOW_STEP);
      q_item.col_hit[g] = (g < GRID_SIDE) && (int'(col) >= g * WINDOW_STEP) &&
                          (int'(col) <= g * WINDOW_STEP + WINDOW_STEP);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row         <= '0;
      col         <= '0;
      map_counter <= '0;
      map_count   <= MAP_COUNT_RST;
    end else begin
      if (cfg_wen) begin
        map_count <= cfg_wdata;
      end
      if (q_push) begin
        if (!col_end) begin
          col <= col + POS_W'(1);
        end else begin
          col <= '0;
          if (!row_end) begin
            row <= row + POS_W'(1);
          end else begin
            row <= '0;
            if (map_next_wide >= map_count) begin
              map_counter <= '0;
            end else begin
              map_counter <= map_next_wide[MAP_NUM_W-1:0];
            end
          end
        end
      end
    end
  end

endmodule

>>> sv/osp_queue.sv
`timescale 1ns / 1ps
module osp_queue #(
  parameter int DEPTH = osp_pkg::QUEUE_DEPTH
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  osp_pkg::osp_item_t push_item,
  output logic               ready,
  output logic               valid,
  output osp_pkg::osp_item_t pop_item,
  input  logic               pop
);
  import osp_pkg::*;

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  osp_item_t        mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign ready    = (count != CNT_W'(DEPTH));
  assign valid    = (count != '0);
  assign pop_item = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + CNT_W'(1);
      end else if (pop && !push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

endmodule

>>> sv/osp_back.sv
`timescale 1ns / 1ps
module osp_back #(
  parameter int GRID_SIDE = osp_pkg::GRID_SIDE_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               q_valid,
  input  osp_pkg::osp_item_t q_item,
  output logic               q_pop,
  osp_pool_if.source         pool
);
  import osp_pkg::*;

  localparam int NUM_WIN = GRID_SIDE * GRID_SIDE;

  logic signed [SUM_W-1:0] sums     [NUM_WIN];
  logic signed [SUM_W-1:0] sums_upd [NUM_WIN];
  logic signed [SUM_W-1:0] snap     [NUM_WIN];
  logic [MAP_NUM_W-1:0]    snap_map;
  logic [IDX_W-1:0]        emit_idx;
  logic                    draining;
  logic                    xfer;
  logic                    final_xfer;
  logic                    load;

  assign xfer       = pool.valid && pool.ready;
  assign final_xfer = xfer && (emit_idx == IDX_W'(NUM_WIN - 1));

  // A map end waits until the previous run of sums has left, or is leaving now.
  assign q_pop = q_valid && (!q_item.map_end || !draining || final_xfer);
  assign load  = q_pop && q_item.map_end;

  always_comb begin
    for (int r = 0; r < GRID_SIDE; r++) begin
      for (int c = 0; c < GRID_SIDE; c++) begin
        if (q_item.row_hit[r] && q_item.col_hit[c]) begin
          sums_upd[r * GRID_SIDE + c] = sat_add(sums[r * GRID_SIDE + c], q_item.response);
        end else begin
          sums_upd[r * GRID_SIDE + c] = sums[r * GRID_SIDE + c];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int w = 0; w < NUM_WIN; w++) begin
        sums[w] <= '0;
      end
    end else if (q_pop) begin
      for (int w = 0; w < NUM_WIN; w++) begin
        sums[w] <= q_item.map_end ? '0 : sums_upd[w];
      end
    end
  end

  // The finished sums move into a shift bank that feeds the output.
  always_ff @(posedge clk) begin
    if (load) begin
      for (int w = 0; w < NUM_WIN; w++) begin
        snap[w] <= sums_upd[w];
      end
      snap_map <= q_item.map_number;
    end else if (xfer) begin
      for (int w = 0; w < NUM_WIN - 1; w++) begin
        snap[w] <= snap[w + 1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      draining <= 1'b0;
      emit_idx <= '0;
    end else if (load) begin
      draining <= 1'b1;
      emit_idx <= '0;
    end else if (final_xfer) begin
      draining <= 1'b0;
      emit_idx <= '0;
    end else if (xfer) begin
      emit_idx <= emit_idx + IDX_W'(1);
    end
  end

  assign pool.valid        = draining;
  assign pool.region_sum   = snap[0];
  assign pool.region_index = emit_idx;
  assign pool.map_number   = snap_map;
  assign pool.last_region  = (emit_idx == IDX_W'(NUM_WIN - 1));

endmodule
